>>> rtl/core/rfs_pkg.sv
package rfs_pkg;

    localparam int SIZE_W  = 13;
    localparam int CUT_W   = 16;
    localparam int COORD_W = 12;
    localparam int GREY_W  = 8;
    localparam int OFS_W   = 13;
    localparam int SUM_W   = 27;
    localparam int ROOT_W  = 30;
    localparam int Q_W     = 16;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] CFG_IMAGE_SIZE = 2'd0;
    localparam logic [IDX_W-1:0] CFG_CUTOFF     = 2'd1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd256;
    localparam logic [CUT_W-1:0]  CUT_RESET  = 16'd32768;

    typedef struct packed {
        logic outside;
        logic white;
    } t_side;

endpackage

>>> rtl/core/rfs_div.sv
module rfs_div
    import rfs_pkg::*;
#(
    parameter int DW = 14,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_bits,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_valid [QW];
    logic [DW-1:0] r_rem   [QW];
    logic [QW-1:0] r_bits  [QW];
    logic [QW-1:0] r_quo   [QW];
    logic [SW-1:0] r_side  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          w_valid;
        logic [DW-1:0] w_rem;
        logic [QW-1:0] w_bits;
        logic [QW-1:0] w_quo;
        logic [SW-1:0] w_side;
        logic [DW:0]   w_trial;
        logic [DW:0]   w_diff;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_rem   = i_rem;
            assign w_bits  = i_bits;
            assign w_quo   = '0;
            assign w_side  = i_side;
        end else begin : g_next
            assign w_valid = r_valid[k-1];
            assign w_rem   = r_rem[k-1];
            assign w_bits  = r_bits[k-1];
            assign w_quo   = r_quo[k-1];
            assign w_side  = r_side[k-1];
        end

        assign w_trial = {w_rem, w_bits[QW-1]};
        assign w_diff  = w_trial - {1'b0, i_den};
        assign w_ge    = (w_trial >= {1'b0, i_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_bits[k] <= {w_bits[QW-2:0], 1'b0};
            r_quo[k]  <= {w_quo[QW-2:0], w_ge};
            r_side[k] <= w_side;
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

>>> rtl/core/rfs_sqrt.sv
module rfs_sqrt
    import rfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SUM_W-1:0]  i_sum,
    input  logic              i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic              o_side
);

    localparam int XW = 2 * ROOT_W;
    localparam int RW = ROOT_W + 2;

    logic              r_valid [ROOT_W];
    logic [XW-1:0]     r_x     [ROOT_W];
    logic [RW-1:0]     r_rem   [ROOT_W];
    logic [ROOT_W-1:0] r_root  [ROOT_W];
    logic              r_side  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              w_valid;
        logic [XW-1:0]     w_x;
        logic [RW-1:0]     w_rem;
        logic [ROOT_W-1:0] w_root;
        logic              w_side;
        logic [RW+1:0]     w_trial;
        logic [RW+1:0]     w_test;
        logic [RW+1:0]     w_diff;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_x     = {{(XW-SUM_W-32){1'b0}}, i_sum, 32'd0};
            assign w_rem   = '0;
            assign w_root  = '0;
            assign w_side  = i_side;
        end else begin : g_next
            assign w_valid = r_valid[k-1];
            assign w_x     = r_x[k-1];
            assign w_rem   = r_rem[k-1];
            assign w_root  = r_root[k-1];
            assign w_side  = r_side[k-1];
        end

        assign w_trial = {w_rem, w_x[XW-1:XW-2]};
        assign w_test  = {2'b00, w_root, 2'b01};
        assign w_diff  = w_trial - w_test;
        assign w_ge    = (w_trial >= w_test);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[k]    <= {w_x[XW-3:0], 2'b00};
            r_rem[k]  <= w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
            r_root[k] <= {w_root[ROOT_W-2:0], w_ge};
            r_side[k] <= w_side;
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

>>> rtl/core/radial_falloff_stencil.sv
// Channel  Handshake                  Payload
// input    start high, busy low       i_row, i_col
// result   o_strobe, one cycle        o_grey
// config   i_cfg_valid & o_cfg_ready  i_cfg_index, i_cfg_data
//
// One pixel is taken in every cycle and busy never rises.
// Each transaction passes in order through the offset and squaring registers, 30
// square root stages, 16 stages of the distance divider, one ramp stage, 8 stages
// of the ramp divider and the output register.
// Synchronous active-low reset clears the stage valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
module radial_falloff_stencil
    import rfs_pkg::*;
#(
    parameter int MAX_SIZE = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [COORD_W-1:0] i_row,
    input  logic [COORD_W-1:0] i_col,
    output logic               o_strobe,
    output logic [GREY_W-1:0]  o_grey,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CUT_W-1:0]   i_cfg_data
);

    localparam logic [SIZE_W-1:0] SIZE_CLAMP =
        (MAX_SIZE > 8191) ? 13'h1FFF : SIZE_W'(MAX_SIZE);

    logic [SIZE_W-1:0] r_size;
    logic [CUT_W-1:0]  r_cut;
    logic [SIZE_W-1:0] w_n;
    logic              w_accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
            r_cut  <= CUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IMAGE_SIZE: r_size <= i_cfg_data[SIZE_W-1:0];
                CFG_CUTOFF:     r_cut  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_n = r_size;
        if (w_n == '0) begin
            w_n = 13'd1;
        end
        if (w_n > SIZE_CLAMP) begin
            w_n = SIZE_CLAMP;
        end
    end

    function automatic logic [OFS_W-1:0] ofs(input logic [COORD_W-1:0] p,
                                             input logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] ps;
        logic [SIZE_W-1:0] a;
        ps = {1'b0, p};
        if (ps >= n) begin
            ps = n - 13'd1;
        end
        a = {ps[SIZE_W-2:0], 1'b1};
        return (a >= n) ? (a - n) : (n - a);
    endfunction

    logic             r_a_valid;
    logic [OFS_W-1:0] r_dx;
    logic [OFS_W-1:0] r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= ofs(i_row, w_n);
        r_dy <= ofs(i_col, w_n);
    end

    logic               r_b_valid;
    logic [SUM_W-1:0]   r_sum;
    logic               r_b_out;
    logic [2*OFS_W-1:0] w_dx2;
    logic [2*OFS_W-1:0] w_dy2;
    logic [SUM_W-1:0]   w_sum;
    logic [SUM_W-2:0]   w_nn;

    assign w_dx2 = r_dx * r_dx;
    assign w_dy2 = r_dy * r_dy;
    assign w_sum = {1'b0, w_dx2} + {1'b0, w_dy2};
    assign w_nn  = w_n * w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum   <= w_sum;
        r_b_out <= (w_sum >= {1'b0, w_nn});
    end

    logic              w_sq_valid;
    logic [ROOT_W-1:0] w_root;
    logic              w_sq_out;

    rfs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_valid),
        .i_sum   (r_sum),
        .i_side  (r_b_out),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_sq_out)
    );

    logic           w_d1_valid;
    logic [Q_W-1:0] w_q;
    logic           w_d1_out;

    rfs_div #(
        .DW (SIZE_W + 1),
        .QW (Q_W),
        .SW (1)
    ) u_dist_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .i_rem   (w_root[ROOT_W-1:Q_W]),
        .i_bits  (w_root[Q_W-1:0]),
        .i_den   ({1'b0, w_n}),
        .i_side  (w_sq_out),
        .o_valid (w_d1_valid),
        .o_quo   (w_q),
        .o_side  (w_d1_out)
    );

    logic          r_c_valid;
    logic [23:0]   r_num;
    t_side         r_c_side;
    logic [Q_W:0]  w_span;
    logic [Q_W:0]  w_den;
    logic [24:0]   w_num;

    assign w_span = 17'h10000 - {1'b0, w_q};
    assign w_den  = 17'h10000 - {1'b0, r_cut};
    assign w_num  = {w_span, 8'd0} - {8'd0, w_span};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= w_d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num            <= w_num[23:0];
        r_c_side.outside <= w_d1_out;
        r_c_side.white   <= (w_q < r_cut);
    end

    logic              w_d2_valid;
    logic [GREY_W-1:0] w_ramp;
    t_side             w_d2_side;

    rfs_div #(
        .DW (Q_W + 1),
        .QW (GREY_W),
        .SW ($bits(t_side))
    ) u_ramp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c_valid),
        .i_rem   ({1'b0, r_num[23:8]}),
        .i_bits  (r_num[7:0]),
        .i_den   (w_den),
        .i_side  (r_c_side),
        .o_valid (w_d2_valid),
        .o_quo   (w_ramp),
        .o_side  (w_d2_side)
    );

    logic              r_strobe;
    logic [GREY_W-1:0] r_grey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d2_side.outside) begin
            r_grey <= '0;
        end else if (w_d2_side.white) begin
            r_grey <= '1;
        end else begin
            r_grey <= w_ramp;
        end
    end

    assign o_strobe = r_strobe;
    assign o_grey   = r_grey;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 58))
        else $error("result strobe without a matching transaction");

    a_outside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_c_side.outside) |-> ##9 (o_strobe && o_grey == '0))
        else $error("pixel beyond unit radius did not come out black");

    a_white_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_c_side.white && !r_c_side.outside) |-> ##9 (o_strobe && o_grey == '1))
        else $error("pixel inside cutoff did not come out white");

endmodule
